@@ rtl/matrix_find_nonzero_core_macros.svh @@
// Assertion macros for the nonzero finder RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef MATRIX_FIND_NONZERO_CORE_MACROS_SVH
`define MATRIX_FIND_NONZERO_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MFN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mfn assertion failed");
`define MFN_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("mfn assertion failed");
`else
`define MFN_ASSERT(lbl, prop)
`define MFN_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/mfn_pkg.sv @@
// Types, constants and helper functions of the nonzero finder.
// No dependencies; used by every module of the block.
package mfn_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int PosW    = 13;
  localparam int DimW    = 7;
  localparam int IdxW    = 6;
  localparam int ColAw   = $clog2(MaxCols);
  localparam int RowAw   = $clog2(MaxRows);

  localparam logic [1:0] ModeAll = 2'd0;
  localparam logic [1:0] ModeRow = 2'd1;
  localparam logic [1:0] ModeCol = 2'd2;
  localparam logic [1:0] ModeMap = 2'd3;

  localparam logic [1:0] RegFindMode = 2'd0;
  localparam logic [1:0] RegDirLast  = 2'd1;
  localparam logic [1:0] RegNumRows  = 2'd2;
  localparam logic [1:0] RegNumCols  = 2'd3;

  typedef struct packed {
    logic [1:0]      mode;
    logic            dir_last;
    logic [DimW-1:0] rows;
    logic [DimW-1:0] cols;
  } cfg_t;

  typedef struct packed {
    logic             nz;
    logic [ColAw-1:0] col;
    logic             first_row;
    logic             row_end;
    logic             last_row;
    logic             final_elem;
    logic [PosW-1:0]  pos;
  } item_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            is_entry;
    logic [DimW-1:0] out_rows;
    logic [PosW-1:0] out_cols;
    logic            last;
  } res_t;

  function automatic logic [PosW-1:0] pick(input logic dir_last, input logic [PosW-1:0] best,
                                           input logic nz, input logic [PosW-1:0] pos);
    logic [PosW-1:0] r;
    r = best;
    if (nz && (dir_last || (best == '0))) r = pos;
    return r;
  endfunction

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v, input int maxv);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > DimW'(maxv)) r = DimW'(maxv);
    return r;
  endfunction

endpackage

@@ rtl/mfn_cfg.sv @@
// APB register file: mode, direction and matrix dimensions.
// Depends on mfn_pkg; issues a restart pulse on every register write.
module mfn_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mfn_pkg::cfg_t      cfg_o,
  output logic               restart_o
);

  logic [1:0]               find_mode_q;
  logic                     dir_last_q;
  logic [mfn_pkg::DimW-1:0] num_rows_q;
  logic [mfn_pkg::DimW-1:0] num_cols_q;
  logic                     wr_en;

  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite;
  assign restart_o = wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      find_mode_q <= mfn_pkg::ModeAll;
      dir_last_q  <= 1'b0;
      num_rows_q  <= mfn_pkg::DimW'(1);
      num_cols_q  <= mfn_pkg::DimW'(1);
    end else if (wr_en) begin
      case (paddr[3:2])
        mfn_pkg::RegFindMode: find_mode_q <= pwdata[1:0];
        mfn_pkg::RegDirLast:  dir_last_q  <= pwdata[0];
        mfn_pkg::RegNumRows:  num_rows_q  <= pwdata[mfn_pkg::DimW-1:0];
        mfn_pkg::RegNumCols:  num_cols_q  <= pwdata[mfn_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mfn_pkg::RegFindMode: prdata = {30'd0, find_mode_q};
      mfn_pkg::RegDirLast:  prdata = {31'd0, dir_last_q};
      mfn_pkg::RegNumRows:  prdata = {25'd0, num_rows_q};
      mfn_pkg::RegNumCols:  prdata = {25'd0, num_cols_q};
      default:              prdata = '0;
    endcase
  end

  assign cfg_o.mode     = find_mode_q;
  assign cfg_o.dir_last = dir_last_q;
  assign cfg_o.rows     = mfn_pkg::clamp_dim(num_rows_q, mfn_pkg::MaxRows);
  assign cfg_o.cols     = mfn_pkg::clamp_dim(num_cols_q, mfn_pkg::MaxCols);

endmodule

@@ rtl/mfn_index_gen.sv @@
// Input register and row/column/linear position counters.
// Depends on mfn_pkg; feeds one decoded element request to the result stage.
module mfn_index_gen (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mfn_pkg::cfg_t             cfg_i,
  input  logic                      restart_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [31:0]               elem_value_i,
  input  logic                      a_move_i,
  output logic                      a_valid_o,
  output mfn_pkg::item_t            item_o,
  output logic                      rd_en_o,
  output logic [mfn_pkg::ColAw-1:0] rd_addr_o
);

  logic [mfn_pkg::IdxW-1:0] row_q, row_d;
  logic [mfn_pkg::IdxW-1:0] col_q, col_d;
  logic [mfn_pkg::PosW-1:0] lin_q, lin_d;
  logic                     a_valid_q;
  mfn_pkg::item_t           item_q;
  logic                     accept;
  logic                     row_end;
  logic                     last_row;
  logic                     final_elem;

  assign in_ready_o = !a_valid_q || a_move_i;
  assign accept     = in_valid_i && in_ready_o;
  assign row_end    = ({1'b0, col_q} + mfn_pkg::DimW'(1)) >= cfg_i.cols;
  assign last_row   = ({1'b0, row_q} + mfn_pkg::DimW'(1)) >= cfg_i.rows;
  assign final_elem = row_end && last_row;
  assign rd_en_o    = accept;
  assign rd_addr_o  = col_q[mfn_pkg::ColAw-1:0];

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    lin_d = lin_q;
    if (restart_i) begin
      row_d = '0;
      col_d = '0;
      lin_d = '0;
    end else if (accept) begin
      if (final_elem) begin
        row_d = '0;
        col_d = '0;
        lin_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + mfn_pkg::IdxW'(1);
        lin_d = lin_q + mfn_pkg::PosW'(1);
      end else begin
        col_d = col_q + mfn_pkg::IdxW'(1);
        lin_d = lin_q + mfn_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      lin_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      lin_q <= lin_d;
      if (accept) a_valid_q <= 1'b1;
      else if (a_move_i) a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.nz         <= elem_value_i[30:0] != '0;
      item_q.col        <= col_q[mfn_pkg::ColAw-1:0];
      item_q.first_row  <= row_q == '0;
      item_q.row_end    <= row_end;
      item_q.last_row   <= last_row;
      item_q.final_elem <= final_elem;
      item_q.pos        <= lin_q + mfn_pkg::PosW'(1);
    end
  end

  assign a_valid_o = a_valid_q;
  assign item_o    = item_q;

endmodule

@@ rtl/mfn_col_store.sv @@
// Per-column best-position memory with registered read and write forwarding.
// Depends on mfn_pkg for widths.
module mfn_col_store (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [mfn_pkg::ColAw-1:0] rd_addr_i,
  output logic [mfn_pkg::PosW-1:0]  rd_data_o,
  input  logic                      wr_en_i,
  input  logic [mfn_pkg::ColAw-1:0] wr_addr_i,
  input  logic [mfn_pkg::PosW-1:0]  wr_data_i
);

  logic [mfn_pkg::PosW-1:0] mem [mfn_pkg::MaxCols];
  logic [mfn_pkg::PosW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) rd_q <= wr_data_i;
      else rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

@@ rtl/mfn_result.sv @@
// Result stage: running count, row best, column update and output register.
// Depends on mfn_pkg and the assertion macros header.
`include "matrix_find_nonzero_core_macros.svh"
module mfn_result (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mfn_pkg::cfg_t             cfg_i,
  input  logic                      restart_i,
  input  logic                      a_valid_i,
  input  mfn_pkg::item_t            item_i,
  output logic                      a_move_o,
  input  logic [mfn_pkg::PosW-1:0]  cb_rd_i,
  output logic                      wr_en_o,
  output logic [mfn_pkg::ColAw-1:0] wr_addr_o,
  output logic [mfn_pkg::PosW-1:0]  wr_data_o,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output mfn_pkg::res_t             res_o
);

  logic [mfn_pkg::PosW-1:0] found_q, found_d;
  logic [mfn_pkg::PosW-1:0] best_q, best_d;
  logic [mfn_pkg::PosW-1:0] cb_base, cb_new, rb_new, fc_new, nz_pos;
  logic                     m_valid_q;
  mfn_pkg::res_t            res_q, res_d;
  logic                     emit;
  logic                     b_free;

  assign b_free   = !m_valid_q || m_ready_i;
  assign a_move_o = a_valid_i && b_free;

  assign cb_base = item_i.first_row ? '0 : cb_rd_i;
  assign cb_new  = mfn_pkg::pick(cfg_i.dir_last, cb_base, item_i.nz, item_i.pos);
  assign rb_new  = mfn_pkg::pick(cfg_i.dir_last, best_q, item_i.nz, item_i.pos);
  assign fc_new  = found_q + mfn_pkg::PosW'(item_i.nz);
  assign nz_pos  = item_i.nz ? item_i.pos : '0;

  assign wr_en_o   = a_move_o;
  assign wr_addr_o = item_i.col;
  assign wr_data_o = cb_new;

  always_comb begin
    emit           = 1'b1;
    res_d.position = nz_pos;
    res_d.is_entry = 1'b1;
    res_d.out_rows = '0;
    res_d.out_cols = '0;
    res_d.last     = item_i.final_elem;
    case (cfg_i.mode)
      mfn_pkg::ModeAll: begin
        emit           = item_i.nz || item_i.final_elem;
        res_d.is_entry = item_i.nz;
        if (item_i.final_elem) begin
          res_d.out_rows = mfn_pkg::DimW'(1);
          res_d.out_cols = fc_new;
        end
      end
      mfn_pkg::ModeRow: begin
        emit           = item_i.row_end;
        res_d.position = rb_new;
        if (item_i.final_elem) begin
          res_d.out_rows = cfg_i.rows;
          res_d.out_cols = mfn_pkg::PosW'(1);
        end
      end
      mfn_pkg::ModeCol: begin
        emit           = item_i.last_row;
        res_d.position = cb_new;
        if (item_i.final_elem) begin
          res_d.out_rows = mfn_pkg::DimW'(1);
          res_d.out_cols = mfn_pkg::PosW'(cfg_i.cols);
        end
      end
      default: begin
        if (item_i.final_elem) begin
          res_d.out_rows = cfg_i.rows;
          res_d.out_cols = mfn_pkg::PosW'(cfg_i.cols);
        end
      end
    endcase
  end

  always_comb begin
    found_d = found_q;
    best_d  = best_q;
    if (restart_i) begin
      found_d = '0;
      best_d  = '0;
    end else if (a_move_o) begin
      found_d = item_i.final_elem ? '0 : fc_new;
      best_d  = item_i.row_end ? '0 : rb_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= '0;
      best_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      found_q <= found_d;
      best_q  <= best_d;
      if (a_move_o && emit) m_valid_q <= 1'b1;
      else if (m_ready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move_o && emit) res_q <= res_d;
  end

  assign m_valid_o = m_valid_q;
  assign res_o     = res_q;

  `MFN_ASSERT(a_move_needs_item, a_move_o |-> a_valid_i)
  `MFN_ASSERT(stalled_result_kept, (m_valid_q && !m_ready_i) |=> m_valid_q)
  `MFN_ASSERT(all_mode_final_out,
    (a_move_o && item_i.final_elem && (cfg_i.mode == mfn_pkg::ModeAll))
      |=> (m_valid_q && res_q.last))

endmodule

@@ rtl/matrix_find_nonzero_core.sv @@
// Nonzero finder over a row-major matrix stream of IEEE-754 single elements.
// Two register stages: an accepted element is registered as an item, then its result in the output register.
// Throughput: one element per cycle while the output accepts results; the column store is read one request ahead.
// Reset: configuration returns to mode all, first, 1x1; counters clear.
// The column store is not cleared; each entry is written on the first row.
module matrix_find_nonzero_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] elem_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [12:0] position, [19:13] out_rows, [32:20] out_cols
  output logic        m_axis_tuser,   // [0] is_entry
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mfn_pkg::cfg_t               cfg;
  logic                        restart;
  logic                        a_valid;
  logic                        a_move;
  mfn_pkg::item_t              item;
  logic                        rd_en;
  logic [mfn_pkg::ColAw-1:0]   rd_addr;
  logic [mfn_pkg::PosW-1:0]    rd_data;
  logic                        wr_en;
  logic [mfn_pkg::ColAw-1:0]   wr_addr;
  logic [mfn_pkg::PosW-1:0]    wr_data;
  mfn_pkg::res_t               res;

  mfn_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  mfn_index_gen u_index_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .restart_i    (restart),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .elem_value_i (s_axis_tdata),
    .a_move_i     (a_move),
    .a_valid_o    (a_valid),
    .item_o       (item),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr)
  );

  mfn_col_store u_col_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  mfn_result u_result (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (restart),
    .a_valid_i (a_valid),
    .item_i    (item),
    .a_move_o  (a_move),
    .cb_rd_i   (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res)
  );

  assign m_axis_tdata = {7'd0, res.out_cols, res.out_rows, res.position};
  assign m_axis_tuser = res.is_entry;
  assign m_axis_tlast = res.last;

endmodule
